### sv/pstc_pkg.sv
// Shared constants for the per-signal transition counter.
`default_nettype none

package pstc_pkg;

	// Fixed widths of the sample and result fields.
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned LEVEL_W = 2;
	localparam int unsigned TOTAL_W = 32;

	// Level codes; any other code is an unknown level.
	localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd1;

	typedef logic [LEVEL_W-1:0] level_t;

endpackage

`default_nettype wire

### sv/per_signal_transition_counter.sv
// Top level of the per-signal transition counter: record memory, update stage and result register.
`default_nettype none

// The block keeps one activity record per signal (stored level plus saturating
// update, rise and fall counters) in a synchronous memory, with a flip-flop valid
// bit per record that reset clears at once, so no clearing pass is needed.
// It takes one sample per cycle while the result side is not stalling: the memory is read
// at acceptance into the update stage, the record is updated and written back when that
// stage advances, and the result lands in the output register at that same edge.
// A write to the same record in the cycle of a read is forwarded into the update
// stage, which keeps back-to-back samples of one signal correct. Samples whose
// index is at or beyond NUM_SIGNALS leave the state alone and give all-zero results.
// Only the first 256 records are reachable through the 8-bit index.
module per_signal_transition_counter #(
	parameter int NUM_SIGNALS = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  sample_valid,
	output logic                                 sample_ready,
	input  wire  [pstc_pkg::INDEX_W-1:0]         signal_index,
	input  wire  [pstc_pkg::LEVEL_W-1:0]         level,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output logic                                 created,
	output logic [pstc_pkg::TOTAL_W-1:0]         update_total,
	output logic [pstc_pkg::TOTAL_W-1:0]         rise_total,
	output logic [pstc_pkg::TOTAL_W-1:0]         fall_total
);

	localparam int REACH  = 1 << pstc_pkg::INDEX_W;
	localparam int DEPTH  = (NUM_SIGNALS < REACH) ? NUM_SIGNALS : REACH;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef struct packed {
		pstc_pkg::level_t       lvl;
		logic [COUNT_WIDTH-1:0] upd;
		logic [COUNT_WIDTH-1:0] rise;
		logic [COUNT_WIDTH-1:0] fall;
	} record_t;

	record_t             mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;

	// Update stage.
	logic                valid_s1;
	logic                in_range_s1;
	logic                entry_valid_s1;
	logic                fwd_s1;
	record_t             fwd_data_s1;
	record_t             rdata_s1;
	logic [ADDR_W-1:0]   addr_s1;
	pstc_pkg::level_t    level_s1;

	logic                accept;
	logic                s1_adv;
	logic                in_range;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	record_t             cur;
	record_t             upd_rec;
	logic                res_created;
	logic [63:0]         upd_ext;
	logic [63:0]         rise_ext;
	logic [63:0]         fall_ext;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	assign rd_addr  = signal_index[ADDR_W-1:0];
	assign in_range = (32'(signal_index) < NUM_SIGNALS);
	assign s1_adv   = !result_valid || result_ready;
	assign sample_ready = !valid_s1 || s1_adv;
	assign accept   = sample_valid && sample_ready;
	assign wr_en    = valid_s1 && s1_adv && in_range_s1;

	always_comb begin
		cur         = fwd_s1 ? fwd_data_s1 : rdata_s1;
		upd_rec     = cur;
		res_created = 1'b0;
		if (!entry_valid_s1) begin
			upd_rec     = '{lvl: level_s1, upd: '0, rise: '0, fall: '0};
			res_created = 1'b1;
		end else begin
			if (cur.lvl == pstc_pkg::LEVEL_LOW && level_s1 == pstc_pkg::LEVEL_HIGH) begin
				upd_rec.rise = sat_inc(cur.rise);
			end else if (cur.lvl == pstc_pkg::LEVEL_HIGH && level_s1 == pstc_pkg::LEVEL_LOW) begin
				upd_rec.fall = sat_inc(cur.fall);
			end
			upd_rec.lvl = level_s1;
			upd_rec.upd = sat_inc(cur.upd);
		end
		upd_ext  = 64'(upd_rec.upd);
		rise_ext = 64'(upd_rec.rise);
		fall_ext = 64'(upd_rec.fall);
	end

	// Record memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= upd_rec;
		end
		if (accept) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// A write landing on the record being read this cycle is caught here,
	// since the memory read returns the old contents.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1    <= in_range;
			addr_s1        <= rd_addr;
			level_s1       <= level;
			fwd_s1         <= wr_en && (addr_s1 == rd_addr);
			fwd_data_s1    <= upd_rec;
			entry_valid_s1 <= in_range && (valid_q[rd_addr] || (wr_en && addr_s1 == rd_addr));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			created      <= in_range_s1 && res_created;
			update_total <= in_range_s1 ? upd_ext[pstc_pkg::TOTAL_W-1:0] : '0;
			rise_total   <= in_range_s1 ? rise_ext[pstc_pkg::TOTAL_W-1:0] : '0;
			fall_total   <= in_range_s1 ? fall_ext[pstc_pkg::TOTAL_W-1:0] : '0;
		end
	end

`ifndef SYNTHESIS
	a_created_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && created |-> update_total == '0 && rise_total == '0 && fall_total == '0)
		else $error("created result carries nonzero totals");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |-> !sample_ready)
		else $error("sample transfer taken while update stage is stalled");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> valid_s1 && in_range_s1)
		else $error("record written without an in-range sample");

	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(addr_s1)])
		else $error("written record not marked valid");
`endif

endmodule

`default_nettype wire

### tb/sv/per_signal_transition_counter_tb.sv
// Self-checking testbench for the per-signal transition counter.
module per_signal_transition_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIGNAL_COUNT = 256;
	localparam int COUNT_W      = 32;
	localparam int RANDOM_ITEMS = 950;
	localparam int SEGMENT_LEN  = 50;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int PRINT_LIMIT  = 50;

	typedef logic [pstc_pkg::INDEX_W-1:0] index_t;

	// Level codes outside low and high; both mean an unknown level.
	localparam pstc_pkg::level_t LEVEL_UNK_A = 2'd2;
	localparam pstc_pkg::level_t LEVEL_UNK_B = 2'd3;

	typedef struct packed {
		logic                         created;
		logic [pstc_pkg::TOTAL_W-1:0] update_total;
		logic [pstc_pkg::TOTAL_W-1:0] rise_total;
		logic [pstc_pkg::TOTAL_W-1:0] fall_total;
	} activity_result_t;

	class activity_scoreboard;
		bit                 seen       [SIGNAL_COUNT];
		pstc_pkg::level_t   held_level [SIGNAL_COUNT];
		logic [COUNT_W-1:0] updates    [SIGNAL_COUNT];
		logic [COUNT_W-1:0] rises      [SIGNAL_COUNT];
		logic [COUNT_W-1:0] falls      [SIGNAL_COUNT];
		activity_result_t   awaited[$];
		int                 n_samples, n_created, n_rises, n_falls, n_unknown;

		function new();
			foreach (seen[i]) seen[i] = 1'b0;
		endfunction

		function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// Applies one accepted sample to the record table and queues its result.
		function void note_sample(logic [pstc_pkg::INDEX_W-1:0] idx, pstc_pkg::level_t lvl);
			activity_result_t res;
			res = '0;
			n_samples++;
			if (lvl != pstc_pkg::LEVEL_LOW && lvl != pstc_pkg::LEVEL_HIGH) n_unknown++;
			if (int'(idx) < SIGNAL_COUNT) begin
				if (!seen[idx]) begin
					seen[idx]       = 1'b1;
					held_level[idx] = lvl;
					updates[idx]    = '0;
					rises[idx]      = '0;
					falls[idx]      = '0;
					res.created     = 1'b1;
					n_created++;
				end else begin
					if (held_level[idx] == pstc_pkg::LEVEL_LOW && lvl == pstc_pkg::LEVEL_HIGH) begin
						rises[idx] = bump(rises[idx]);
						n_rises++;
					end else if (held_level[idx] == pstc_pkg::LEVEL_HIGH &&
						lvl == pstc_pkg::LEVEL_LOW) begin
						falls[idx] = bump(falls[idx]);
						n_falls++;
					end
					held_level[idx]  = lvl;
					updates[idx]     = bump(updates[idx]);
					res.update_total = updates[idx][pstc_pkg::TOTAL_W-1:0];
					res.rise_total   = rises[idx][pstc_pkg::TOTAL_W-1:0];
					res.fall_total   = falls[idx][pstc_pkg::TOTAL_W-1:0];
				end
			end
			awaited.push_back(res);
		endfunction

		// Returns an empty string when the result matches the oldest expectation.
		function string check_result(activity_result_t got);
			activity_result_t want;
			string msg;
			msg = "";
			if (awaited.size() == 0) begin
				return $sformatf("result with nothing pending: created=%0d upd=%0d rise=%0d fall=%0d",
					got.created, got.update_total, got.rise_total, got.fall_total);
			end
			want = awaited.pop_front();
			if (got.created !== want.created)
				msg = {msg, $sformatf(" created %0d/%0d", got.created, want.created)};
			if (got.update_total !== want.update_total)
				msg = {msg, $sformatf(" update_total %0d/%0d", got.update_total, want.update_total)};
			if (got.rise_total !== want.rise_total)
				msg = {msg, $sformatf(" rise_total %0d/%0d", got.rise_total, want.rise_total)};
			if (got.fall_total !== want.fall_total)
				msg = {msg, $sformatf(" fall_total %0d/%0d", got.fall_total, want.fall_total)};
			if (msg != "") msg = {"field mismatch (got/expected):", msg};
			return msg;
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         sample_valid = 1'b0;
	logic                         sample_ready;
	logic [pstc_pkg::INDEX_W-1:0] signal_index = '0;
	pstc_pkg::level_t             level        = pstc_pkg::LEVEL_LOW;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic                         created;
	logic [pstc_pkg::TOTAL_W-1:0] update_total;
	logic [pstc_pkg::TOTAL_W-1:0] rise_total;
	logic [pstc_pkg::TOTAL_W-1:0] fall_total;

	activity_scoreboard sb;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int rx_max_stall   = 0;
	int rx_hold        = 0;

	per_signal_transition_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.signal_index (signal_index),
		.level        (level),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.created      (created),
		.update_total (update_total),
		.rise_total   (rise_total),
		.fall_total   (fall_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) $display("[%0t] %s", $time, what);
	endtask

	// Both handshakes are observed with the values that stood before the edge.
	always @(posedge clk) begin
		string msg;
		if (arst_n && result_valid && result_ready) begin
			msg = sb.check_result({created, update_total, rise_total, fall_total});
			if (msg != "") report_mismatch(msg);
		end
		if (arst_n && sample_valid && sample_ready) sb.note_sample(signal_index, level);
	end

	// Result side: a random stall before each transfer, or one long hold when asked.
	initial begin
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = $urandom_range(0, rx_max_stall);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	task automatic send_sample(input logic [pstc_pkg::INDEX_W-1:0] idx,
		input pstc_pkg::level_t lvl, input int gap);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		signal_index <= idx;
		level        <= lvl;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
	endtask

	// Creation, rises, falls, unchanged and unknown levels, the end indexes and
	// back-to-back samples of one record and of two interleaved records.
	task automatic run_directed();
		logic [pstc_pkg::INDEX_W-1:0] d_idx [20] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd0, 8'd0,
			8'd255, 8'd255, 8'd255, 8'd255,
			8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd1, 8'd1};
		pstc_pkg::level_t d_lvl [20] = '{pstc_pkg::LEVEL_LOW, pstc_pkg::LEVEL_HIGH,
			pstc_pkg::LEVEL_LOW, pstc_pkg::LEVEL_LOW, LEVEL_UNK_A,
			pstc_pkg::LEVEL_HIGH, LEVEL_UNK_B, pstc_pkg::LEVEL_LOW,
			LEVEL_UNK_B, pstc_pkg::LEVEL_HIGH, pstc_pkg::LEVEL_LOW, pstc_pkg::LEVEL_HIGH,
			pstc_pkg::LEVEL_HIGH, LEVEL_UNK_A, pstc_pkg::LEVEL_LOW, pstc_pkg::LEVEL_HIGH,
			pstc_pkg::LEVEL_HIGH, pstc_pkg::LEVEL_LOW,
			pstc_pkg::LEVEL_HIGH, pstc_pkg::LEVEL_HIGH};
		foreach (d_idx[i]) send_sample(d_idx[i], d_lvl[i], 0);
	endtask

	// Most samples go to a small hot set of signals so that records see long
	// runs of updates; the rest are spread over the whole index range.
	task automatic run_random();
		logic [pstc_pkg::INDEX_W-1:0] hot [4];
		logic [pstc_pkg::INDEX_W-1:0] idx;
		pstc_pkg::level_t             lvl;
		int                           tx_max_gap;
		int                           gap;
		tx_max_gap = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				foreach (hot[i]) hot[i] = index_t'($urandom_range(0, SIGNAL_COUNT - 1));
				case ($urandom_range(0, 2))
					0: tx_max_gap = 0;
					1: tx_max_gap = 3;
					default: tx_max_gap = 18;
				endcase
				case ($urandom_range(0, 2))
					0: rx_max_stall = 0;
					1: rx_max_stall = 3;
					default: rx_max_stall = 18;
				endcase
			end
			if (n == 300) rx_hold = LONG_HOLD;
			if (n == 620) begin
				// Let the block run dry before sending more.
				sample_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 65) begin
				idx = hot[$urandom_range(0, 3)];
				if ($urandom_range(0, 99) < 85)
					lvl = $urandom_range(0, 1) ? pstc_pkg::LEVEL_HIGH : pstc_pkg::LEVEL_LOW;
				else
					lvl = $urandom_range(0, 1) ? LEVEL_UNK_B : LEVEL_UNK_A;
			end else begin
				idx = index_t'($urandom_range(0, SIGNAL_COUNT - 1));
				lvl = pstc_pkg::level_t'($urandom_range(0, 3));
			end
			gap = (n >= 300 && n < 340) ? 0 : $urandom_range(0, tx_max_gap);
			send_sample(idx, lvl, gap);
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d samples: %0d record creations, %0d rises, %0d falls,",
			sb.n_samples, sb.n_created, sb.n_rises, sb.n_falls);
		$display("%0d unknown-level samples, one long result stall and one full drain; %0d mismatches.",
			sb.n_unknown, mismatch_count);
		if (mismatch_count == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### per_signal_transition_counter.f
sv/pstc_pkg.sv
sv/per_signal_transition_counter.sv
tb/sv/per_signal_transition_counter_tb.sv
